// ===== src/psd_pkg.sv =====
// shared types and pipeline constants for the point to segment distance block
`timescale 1ns / 1ps
package psd_pkg;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [32:0] diff_t;
  typedef logic        [32:0] dist_t;

  typedef enum logic [1:0] {
    CLS_START,
    CLS_END,
    CLS_INTERP
  } cls_e;

  // segment ends and query point carried down the pipe
  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t px;
    coord_t py;
  } pts_t;

  // closest point and flag carried through the root stages
  typedef struct packed {
    coord_t cx;
    coord_t cy;
    logic   perp;
  } res_t;

  localparam int DIV_STEPS  = 33;
  localparam int DIV_REM_W  = 67;
  localparam int NUM_W      = DIV_REM_W + DIV_STEPS;
  localparam int SQRT_STEPS = 35;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int SRAD_W     = 2 * SQRT_STEPS;

  localparam int ST_S1 = 0;
  localparam int ST_S2 = 1;
  localparam int ST_S3 = 2;
  localparam int ST_S4 = 3;
  localparam int ST_D0 = 4;
  localparam int ST_C  = ST_D0 + DIV_STEPS + 1;
  localparam int ST_E  = ST_C + 1;
  localparam int ST_F  = ST_E + 1;
  localparam int ST_R0 = ST_F + 1;
  localparam int ST_O  = ST_R0 + SQRT_STEPS + 1;
  localparam int NST   = ST_O + 1;

endpackage

// ===== src/psd_if.sv =====
// request and result channel interfaces
`timescale 1ns / 1ps
interface psd_in_if import psd_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t seg_start_x;
  coord_t seg_start_y;
  coord_t seg_end_x;
  coord_t seg_end_y;
  coord_t point_x;
  coord_t point_y;

  modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  point_x, point_y, input ready);
  modport sink (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                point_x, point_y, output ready);
endinterface

interface psd_out_if import psd_pkg::*; ();
  logic   valid;
  logic   ready;
  dist_t  distance;
  coord_t closest_x;
  coord_t closest_y;
  logic   perpendicular;

  modport source (output valid, distance, closest_x, closest_y, perpendicular,
                  input ready);
  modport sink (input valid, distance, closest_x, closest_y, perpendicular,
                output ready);
endinterface

// ===== src/point_segment_distance.sv =====
// point to segment distance, fully pipelined top level
//
//  channel | dir | handshake         | payload
//  in_i    | in  | valid/ready       | seg start, seg end, point (signed q16.16)
//  out_o   | out | valid/ready       | distance, closest x/y, perpendicular
//
// one request per cycle while out_o is not stalled (33 divider steps, 35 root steps)
// throughput set by the single global pipe enable: no loop, no shared unit
// a stalled result holds the whole pipe; bubbles do not advance separately
// reset clears only the stage valid bits, payload registers are not reset
// zero length segment returns the start point with perpendicular clear
`timescale 1ns / 1ps
module point_segment_distance import psd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  psd_in_if.sink    in_i,
  psd_out_if.source out_o
);

  logic [NST-1:0] vld_q;
  logic           en;

  // whole pipe moves unless a finished result is waiting
  assign en         = !vld_q[ST_O] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_i.valid};
    end
  end

  // s1: differences
  pts_t  s1_pts_q;
  diff_t s1_abx_q, s1_aby_q, s1_apx_q, s1_apy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pts_q <= '{ax: in_i.seg_start_x, ay: in_i.seg_start_y,
                     bx: in_i.seg_end_x, by: in_i.seg_end_y,
                     px: in_i.point_x, py: in_i.point_y};
      s1_abx_q <= {in_i.seg_end_x[31], in_i.seg_end_x} -
                  {in_i.seg_start_x[31], in_i.seg_start_x};
      s1_aby_q <= {in_i.seg_end_y[31], in_i.seg_end_y} -
                  {in_i.seg_start_y[31], in_i.seg_start_y};
      s1_apx_q <= {in_i.point_x[31], in_i.point_x} -
                  {in_i.seg_start_x[31], in_i.seg_start_x};
      s1_apy_q <= {in_i.point_y[31], in_i.point_y} -
                  {in_i.seg_start_y[31], in_i.seg_start_y};
    end
  end

  // s2: four products
  pts_t               s2_pts_q;
  diff_t              s2_abx_q, s2_aby_q;
  logic signed [65:0] s2_pxx_q, s2_pyy_q, s2_sxx_q, s2_syy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_pts_q <= s1_pts_q;
      s2_abx_q <= s1_abx_q;
      s2_aby_q <= s1_aby_q;
      s2_pxx_q <= s1_abx_q * s1_apx_q;
      s2_pyy_q <= s1_aby_q * s1_apy_q;
      s2_sxx_q <= s1_abx_q * s1_abx_q;
      s2_syy_q <= s1_aby_q * s1_aby_q;
    end
  end

  // s3: dot product and squared length
  pts_t               s3_pts_q;
  diff_t              s3_abx_q, s3_aby_q;
  logic signed [66:0] s3_dot_q;
  logic        [65:0] s3_len2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_pts_q  <= s2_pts_q;
      s3_abx_q  <= s2_abx_q;
      s3_aby_q  <= s2_aby_q;
      s3_dot_q  <= 67'(s2_pxx_q) + 67'(s2_pyy_q);
      s3_len2_q <= 66'(s2_sxx_q) + 66'(s2_syy_q);
    end
  end

  // s4: classify, split m * dot into two partial products per axis
  cls_e        s3_cls;
  logic [32:0] s3_mx, s3_my;
  pts_t        s4_pts_q;
  cls_e        s4_cls_q;
  logic [1:0]  s4_neg_q;
  logic [65:0] s4_len2_q;
  logic [65:0] s4_plx_q, s4_phx_q, s4_ply_q, s4_phy_q;

  always_comb begin
    if (s3_len2_q == '0 || s3_dot_q[66] || s3_dot_q == '0) begin
      s3_cls = CLS_START;
    end else if (s3_dot_q[65:0] >= s3_len2_q) begin
      s3_cls = CLS_END;
    end else begin
      s3_cls = CLS_INTERP;
    end
    s3_mx = s3_abx_q[32] ? 33'(-s3_abx_q) : 33'(s3_abx_q);
    s3_my = s3_aby_q[32] ? 33'(-s3_aby_q) : 33'(s3_aby_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_pts_q  <= s3_pts_q;
      s4_cls_q  <= s3_cls;
      s4_neg_q  <= {s3_aby_q[32], s3_abx_q[32]};
      s4_len2_q <= s3_len2_q;
      s4_plx_q  <= 66'(s3_mx) * 66'(s3_dot_q[32:0]);
      s4_phx_q  <= 66'(s3_mx) * 66'(s3_dot_q[65:33]);
      s4_ply_q  <= 66'(s3_my) * 66'(s3_dot_q[32:0]);
      s4_phy_q  <= 66'(s3_my) * 66'(s3_dot_q[65:33]);
    end
  end

  // divider: round(m * dot / len2) as floor((2 m dot + len2) / (2 len2))
  logic [NUM_W-1:0]     num_x, num_y;
  pts_t                 dv_pts_q [DIV_STEPS+1];
  cls_e                 dv_cls_q [DIV_STEPS+1];
  logic [1:0]           dv_neg_q [DIV_STEPS+1];
  logic [DIV_REM_W-1:0] dv_den_q [DIV_STEPS+1];
  logic [DIV_REM_W-1:0] dv_rem_q [DIV_STEPS+1][2];
  logic [DIV_STEPS-1:0] dv_ql_q  [DIV_STEPS+1][2];

  assign num_x = (NUM_W'(s4_phx_q) << 34) + (NUM_W'(s4_plx_q) << 1) + NUM_W'(s4_len2_q);
  assign num_y = (NUM_W'(s4_phy_q) << 34) + (NUM_W'(s4_ply_q) << 1) + NUM_W'(s4_len2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_pts_q[0]    <= s4_pts_q;
      dv_cls_q[0]    <= s4_cls_q;
      dv_neg_q[0]    <= s4_neg_q;
      dv_den_q[0]    <= {s4_len2_q, 1'b0};
      dv_rem_q[0][0] <= num_x[NUM_W-1:DIV_STEPS];
      dv_rem_q[0][1] <= num_y[NUM_W-1:DIV_STEPS];
      dv_ql_q[0][0]  <= num_x[DIV_STEPS-1:0];
      dv_ql_q[0][1]  <= num_y[DIV_STEPS-1:0];
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_pts_q[k+1] <= dv_pts_q[k];
        dv_cls_q[k+1] <= dv_cls_q[k];
        dv_neg_q[k+1] <= dv_neg_q[k];
        dv_den_q[k+1] <= dv_den_q[k];
      end
    end
    for (genvar a = 0; a < 2; a++) begin : g_axis
      logic [DIV_REM_W:0] trial;
      logic               ge;
      // next numerator bit leaves the top of this axis's quotient shifter
      assign trial = {dv_rem_q[k][a], dv_ql_q[k][a][DIV_STEPS-1]};
      assign ge    = trial >= {1'b0, dv_den_q[k]};
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_rem_q[k+1][a] <= ge ? DIV_REM_W'(trial - {1'b0, dv_den_q[k]})
                                 : trial[DIV_REM_W-1:0];
          dv_ql_q[k+1][a]  <= {dv_ql_q[k][a][DIV_STEPS-2:0], ge};
        end
      end
    end
  end

  // c: closest point
  pts_t   dq_pts;
  cls_e   dq_cls;
  logic   dq_negx, dq_negy;
  coord_t qx, qy;
  coord_t c_cx_d, c_cy_d;
  logic   c_perp_d;
  coord_t c_cx_q, c_cy_q, c_px_q, c_py_q;
  logic   c_perp_q;

  assign dq_pts  = dv_pts_q[DIV_STEPS];
  assign dq_cls  = dv_cls_q[DIV_STEPS];
  assign dq_negx = dv_neg_q[DIV_STEPS][0];
  assign dq_negy = dv_neg_q[DIV_STEPS][1];
  // quotient never exceeds |ab| on its axis, so wrapping to 32 bits is exact
  assign qx = coord_t'(dv_ql_q[DIV_STEPS][0][31:0]);
  assign qy = coord_t'(dv_ql_q[DIV_STEPS][1][31:0]);

  always_comb begin
    case (dq_cls)
      CLS_START: begin
        c_cx_d   = dq_pts.ax;
        c_cy_d   = dq_pts.ay;
        c_perp_d = 1'b0;
      end
      CLS_END: begin
        c_cx_d   = dq_pts.bx;
        c_cy_d   = dq_pts.by;
        c_perp_d = 1'b0;
      end
      CLS_INTERP: begin
        c_cx_d   = dq_negx ? dq_pts.ax - qx : dq_pts.ax + qx;
        c_cy_d   = dq_negy ? dq_pts.ay - qy : dq_pts.ay + qy;
        c_perp_d = 1'b1;
      end
      default: begin
        c_cx_d   = dq_pts.ax;
        c_cy_d   = dq_pts.ay;
        c_perp_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_cx_q   <= c_cx_d;
      c_cy_q   <= c_cy_d;
      c_perp_q <= c_perp_d;
      c_px_q   <= dq_pts.px;
      c_py_q   <= dq_pts.py;
    end
  end

  // e: offset magnitudes
  diff_t       e_dx, e_dy;
  res_t        e_res_q;
  logic [32:0] e_mx_q, e_my_q;

  assign e_dx = {c_px_q[31], c_px_q} - {c_cx_q[31], c_cx_q};
  assign e_dy = {c_py_q[31], c_py_q} - {c_cy_q[31], c_cy_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_res_q <= '{cx: c_cx_q, cy: c_cy_q, perp: c_perp_q};
      e_mx_q  <= e_dx[32] ? 33'(-e_dx) : 33'(e_dx);
      e_my_q  <= e_dy[32] ? 33'(-e_dy) : 33'(e_dy);
    end
  end

  // f: squares
  res_t        f_res_q;
  logic [65:0] f_sx_q, f_sy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_res_q <= e_res_q;
      f_sx_q  <= 66'(e_mx_q) * 66'(e_mx_q);
      f_sy_q  <= 66'(e_my_q) * 66'(e_my_q);
    end
  end

  // square root, two radicand bits per stage
  res_t              sq_res_q [SQRT_STEPS+1];
  logic [SREM_W-1:0] sq_rem_q [SQRT_STEPS+1];
  logic [ROOT_W-1:0] sq_root_q[SQRT_STEPS+1];
  logic [SRAD_W-1:0] sq_rad_q [SQRT_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_res_q[0]  <= f_res_q;
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_rad_q[0]  <= SRAD_W'(f_sx_q) + SRAD_W'(f_sy_q);
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [SREM_W+1:0] cur;
    logic [SREM_W+1:0] trial;
    logic              ge;
    assign cur   = {sq_rem_q[k], sq_rad_q[k][SRAD_W-1 -: 2]};
    assign trial = (SREM_W+2)'({sq_root_q[k], 2'b01});
    assign ge    = cur >= trial;
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_res_q[k+1]  <= sq_res_q[k];
        sq_rem_q[k+1]  <= ge ? SREM_W'(cur - trial) : cur[SREM_W-1:0];
        sq_root_q[k+1] <= {sq_root_q[k][ROOT_W-2:0], ge};
        sq_rad_q[k+1]  <= {sq_rad_q[k][SRAD_W-3:0], 2'b00};
      end
    end
  end

  // o: round to nearest, remainder is s - r^2
  res_t              o_res_q;
  dist_t             o_dist_q;
  logic [ROOT_W-1:0] o_root;

  assign o_root = (sq_rem_q[SQRT_STEPS] > SREM_W'(sq_root_q[SQRT_STEPS]))
                  ? sq_root_q[SQRT_STEPS] + ROOT_W'(1) : sq_root_q[SQRT_STEPS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_res_q  <= sq_res_q[SQRT_STEPS];
      o_dist_q <= o_root[32:0];
    end
  end

  assign out_o.valid         = vld_q[ST_O];
  assign out_o.distance      = o_dist_q;
  assign out_o.closest_x     = o_res_q.cx;
  assign out_o.closest_y     = o_res_q.cy;
  assign out_o.perpendicular = o_res_q.perp;

  // a held pipe keeps every stage occupancy
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("stage valid bits moved while the pipe was held");

  // interpolation only on a segment of nonzero length
  a_interp_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_S4] && s4_cls_q == CLS_INTERP) |-> (s4_len2_q != '0))
    else $error("interpolation selected for a zero length segment");

  // divider remainder stays below the divisor on interpolated requests
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_C - 1] && dq_cls == CLS_INTERP) |->
      (dv_rem_q[DIV_STEPS][0] < dv_den_q[DIV_STEPS] &&
       dv_rem_q[DIV_STEPS][1] < dv_den_q[DIV_STEPS]))
    else $error("divider remainder not below divisor");

  // floor root leaves a remainder of at most twice the root
  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_O - 1] |->
      (sq_rem_q[SQRT_STEPS] <= {1'b0, sq_root_q[SQRT_STEPS], 1'b0}))
    else $error("square root remainder out of range");

endmodule
